FILE: sv/sgcr_pkg.sv
package sgcr_pkg;

	localparam int unsigned SCREEN_WIDTH = 240;
	localparam int unsigned FONT_ROWS    = 13;
	localparam int unsigned FONT_COLS    = 8;
	localparam int unsigned MAX_PIX      = 16;

	localparam int unsigned COLOR_W = 16;
	localparam int unsigned GLYPH_W = FONT_COLS;
	localparam int unsigned X_W     = 8;
	localparam int unsigned Y_W     = 9;
	localparam int unsigned CELL_W  = 5;
	localparam int unsigned PIX_W   = $clog2(MAX_PIX);
	localparam int unsigned IDX_W   = 3;

	typedef logic [IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TEXT_COLOR       = 3'd0;
	localparam cfg_idx_t CFG_BACKGROUND_COLOR = 3'd1;
	localparam cfg_idx_t CFG_SHADOW_COLOR     = 3'd2;
	localparam cfg_idx_t CFG_CELL_WIDTH       = 3'd3;
	localparam cfg_idx_t CFG_CELL_HEIGHT      = 3'd4;
	localparam cfg_idx_t CFG_LEFT_INDENT      = 3'd5;

	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST       = 16'd33793;
	localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RST = 16'd0;
	localparam logic [COLOR_W-1:0] SHADOW_COLOR_RST     = 16'd16896;
	localparam logic [CELL_W-1:0]  CELL_WIDTH_RST       = 5'd12;
	localparam logic [CELL_W-1:0]  CELL_HEIGHT_RST      = 5'd17;
	localparam logic [X_W-1:0]     LEFT_INDENT_RST      = 8'd0;

endpackage

FILE: sv/sgcr_glyph_if.sv
interface sgcr_glyph_if
	import sgcr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [GLYPH_W-1:0] glyph_row;

	modport source (output valid, output glyph_row, input ready);
	modport sink (input valid, input glyph_row, output ready);
endinterface

FILE: sv/sgcr_pixel_if.sv
interface sgcr_pixel_if
	import sgcr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_color;
	logic [X_W-1:0]     pixel_x;
	logic [Y_W-1:0]     pixel_y;
	logic               row_end;
	logic               cell_end;

	modport source (output valid, output pixel_color, output pixel_x, output pixel_y,
		output row_end, output cell_end, input ready);
	modport sink (input valid, input pixel_color, input pixel_x, input pixel_y,
		input row_end, input cell_end, output ready);
endinterface

FILE: sv/shadowed_glyph_cell_renderer_top.sv
// Channel   Direction  Handshake      Payload
// glyph     in         valid/ready    glyph_row[7:0]
// pixel     out        valid/ready    pixel_color, pixel_x, pixel_y, row_end, cell_end
// cfg       in         cfg_we         cfg_index[2:0], cfg_data[15:0]
//
// Each glyph row yields min(cell_width, 16) pixels (12 at reset), one per cycle
// while the pixel side is not stalled.
// The next row is taken in the same cycle its predecessor's last pixel moves
// into the output register; a zero-width row never occupies the serializer.
// arst_n clears the cursor, row count and handshake state; config registers take their reset values.
// A stall on the pixel side holds the output register and the serializer.
module shadowed_glyph_cell_renderer_top
	import sgcr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [COLOR_W-1:0] cfg_data,
	sgcr_glyph_if.sink         glyph,
	sgcr_pixel_if.source       pixel
);

	logic [COLOR_W-1:0] text_color_q;
	logic [COLOR_W-1:0] background_color_q;
	logic [COLOR_W-1:0] shadow_color_q;
	logic [CELL_W-1:0]  cell_width_q;
	logic [CELL_W-1:0]  cell_height_q;
	logic [X_W-1:0]     left_indent_q;

	logic [X_W-1:0]     cursor_col_q;
	logic [Y_W-1:0]     cursor_row_q;
	logic [CELL_W-1:0]  cell_row_count_q;
	logic [GLYPH_W-1:0] prev_glyph_q;

	// Row being serialized.
	logic               row_vld_s1;
	logic [GLYPH_W-1:0] cur_s1;
	logic [GLYPH_W-1:0] prev_s1;
	logic [X_W-1:0]     xbase_s1;
	logic [Y_W-1:0]     y_s1;
	logic [CELL_W-1:0]  width_s1;
	logic               last_row_s1;
	logic [PIX_W-1:0]   pix_q;

	logic               out_vld_q;
	logic [COLOR_W-1:0] color_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic               row_end_q;
	logic               cell_end_q;

	logic               emit;
	logic               last_pix;
	logic               accept;
	logic [CELL_W-1:0]  width_eff;
	logic [GLYPH_W-1:0] cur_eff;
	logic               last_row;
	logic [X_W:0]       new_x;
	logic               fits;
	logic [MAX_PIX-1:0] cur_vec;
	logic [MAX_PIX-1:0] prev_vec;
	logic [PIX_W-1:0]   own_idx;
	logic [PIX_W-1:0]   left_idx;
	logic               own_bit;
	logic               shadow_bit;
	logic [COLOR_W-1:0] color_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q       <= TEXT_COLOR_RST;
			background_color_q <= BACKGROUND_COLOR_RST;
			shadow_color_q     <= SHADOW_COLOR_RST;
			cell_width_q       <= CELL_WIDTH_RST;
			cell_height_q      <= CELL_HEIGHT_RST;
			left_indent_q      <= LEFT_INDENT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEXT_COLOR:       text_color_q       <= cfg_data;
				CFG_BACKGROUND_COLOR: background_color_q <= cfg_data;
				CFG_SHADOW_COLOR:     shadow_color_q     <= cfg_data;
				CFG_CELL_WIDTH:       cell_width_q       <= cfg_data[CELL_W-1:0];
				CFG_CELL_HEIGHT:      cell_height_q      <= cfg_data[CELL_W-1:0];
				CFG_LEFT_INDENT:      left_indent_q      <= cfg_data[X_W-1:0];
				default: ;
			endcase
		end
	end

	assign emit     = row_vld_s1 && (!out_vld_q || pixel.ready);
	assign last_pix = ({1'b0, pix_q} + CELL_W'(1)) == width_s1;
	assign glyph.ready = !row_vld_s1 || (emit && last_pix);
	assign accept   = glyph.valid && glyph.ready;

	always_comb begin
		width_eff = (cell_width_q > CELL_W'(MAX_PIX)) ? CELL_W'(MAX_PIX) : cell_width_q;
		cur_eff   = (cell_row_count_q >= CELL_W'(FONT_ROWS)) ? '0 : glyph.glyph_row;
		last_row  = ({1'b0, cell_row_count_q} + (CELL_W+1)'(1)) >= {1'b0, cell_height_q};
		new_x     = {1'b0, cursor_col_q} + (X_W+1)'(width_eff);
		fits      = ({1'b0, new_x} + (X_W+2)'(FONT_COLS)) < (X_W+2)'(SCREEN_WIDTH);
	end

	// Cursor state moves at accept time; the serializer carries its own copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q     <= '0;
			cursor_row_q     <= '0;
			cell_row_count_q <= '0;
			prev_glyph_q     <= '0;
		end else if (accept) begin
			if (last_row) begin
				cell_row_count_q <= '0;
				prev_glyph_q     <= '0;
				if (fits) begin
					cursor_col_q <= new_x[X_W-1:0];
				end else begin
					cursor_col_q <= left_indent_q;
					cursor_row_q <= Y_W'(cursor_row_q + Y_W'(cell_height_q));
				end
			end else begin
				cell_row_count_q <= CELL_W'(cell_row_count_q + CELL_W'(1));
				prev_glyph_q     <= cur_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_s1 <= 1'b0;
			pix_q      <= '0;
		end else if (accept) begin
			// A zero-width row emits nothing and never occupies the serializer.
			row_vld_s1 <= (width_eff != '0);
			pix_q      <= '0;
		end else if (emit) begin
			if (last_pix) begin
				row_vld_s1 <= 1'b0;
			end
			pix_q <= PIX_W'(pix_q + PIX_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur_eff;
			prev_s1     <= prev_glyph_q;
			xbase_s1    <= cursor_col_q;
			y_s1        <= Y_W'(cursor_row_q + Y_W'(cell_row_count_q));
			width_s1    <= width_eff;
			last_row_s1 <= last_row;
		end
	end

	// Column c of the cell sits at bit MAX_PIX-1-c; columns past the font read zero.
	always_comb begin
		cur_vec    = {cur_s1, (MAX_PIX-GLYPH_W)'(0)};
		prev_vec   = {prev_s1, (MAX_PIX-GLYPH_W)'(0)};
		own_idx    = ~pix_q;
		left_idx   = PIX_W'(own_idx + PIX_W'(1));
		own_bit    = cur_vec[own_idx];
		shadow_bit = prev_vec[own_idx] || ((pix_q != '0) && cur_vec[left_idx]);
		if (own_bit) begin
			color_nxt = text_color_q;
		end else if (shadow_bit) begin
			color_nxt = shadow_color_q;
		end else begin
			color_nxt = background_color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (pixel.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			color_q    <= color_nxt;
			x_q        <= X_W'(xbase_s1 + X_W'(pix_q));
			y_q        <= y_s1;
			row_end_q  <= last_pix;
			cell_end_q <= last_pix && last_row_s1;
		end
	end

	assign pixel.valid       = out_vld_q;
	assign pixel.pixel_color = color_q;
	assign pixel.pixel_x     = x_q;
	assign pixel.pixel_y     = y_q;
	assign pixel.row_end     = row_end_q;
	assign pixel.cell_end    = cell_end_q;

endmodule
